[sv/bcss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcss_pkg
// shared types and constants of the beacon clock sync servo
// ----------------------------------------------------------------------------
package bcss_pkg;

  localparam logic [1:0] MODE_OBSERVE = 2'd0;
  localparam logic [1:0] MODE_MISSED  = 2'd1;
  localparam logic [1:0] MODE_ELAPSED = 2'd2;
  localparam logic [1:0] MODE_CONVERT = 2'd3;

  localparam logic [1:0] LS_UNLOCKED  = 2'd0;
  localparam logic [1:0] LS_ACQUIRING = 2'd1;
  localparam logic [1:0] LS_LOCKED    = 2'd2;
  localparam logic [1:0] LS_HOLDOVER  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NOLOCK = 2'd2;

  localparam logic [1:0] REG_LOCK_COUNT      = 2'd0;
  localparam logic [1:0] REG_OUTLIER_LIMIT   = 2'd1;
  localparam logic [1:0] REG_HOLDOVER_MISSES = 2'd2;
  localparam logic [1:0] REG_UNLOCK_TIMEOUT  = 2'd3;

  localparam logic [19:0] PPM_SCALE = 20'd1000000;
  localparam int unsigned DIV_STEPS = 128;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] master_tick_in;
    logic [63:0] local_tick_in;
    logic [63:0] next_pulse_tick;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  lock_state;
    logic signed [63:0] offset_out;
    logic signed [31:0] drift_out;
    logic [62:0] converted_tick;
    logic [63:0] pulse_tick_out;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, evaluate checks
    logic mul_lo;    // multiply low half of numerator
    logic mul_hi;    // multiply high half
    logic div_init;  // start long division
    logic div_step;  // one quotient bit
    logic commit;    // update state and build response
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // observation needs a drift division
    logic div_done;  // quotient complete or overflowed
  } sts_t;

endpackage

[sv/bcss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcss_ctrl
// sequencer for request load, drift multiply, division and commit
// ----------------------------------------------------------------------------
module bcss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bcss_pkg::cmd_t  cmd_o,
  input  bcss_pkg::sts_t  sts_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_MULLO  = 6'b000100,
    S_MULHI  = 6'b001000,
    S_DIV    = 6'b010000,
    S_COMMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // idle with the output slot free or draining this cycle
  assign in_stall_o  = !(state_q == S_IDLE && (!out_valid_q || !out_stall_i));
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.need_div) state_d = S_MULLO;
        else state_d = S_COMMIT;
      end
      S_MULLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MULHI;
      end
      S_MULHI: begin
        cmd_o.mul_hi = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_COMMIT;
        else cmd_o.div_step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |=> out_valid_q) else $error("commit lost response");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |-> !out_valid_q || !out_stall_i)
    else $error("response overwritten");

endmodule

[sv/bcss_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcss_datapath
// servo state, checks, drift multiply and restoring divider
// ----------------------------------------------------------------------------
module bcss_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  bcss_pkg::req_t  req_i,
  input  bcss_pkg::cmd_t  cmd_i,
  output bcss_pkg::sts_t  sts_o,
  output bcss_pkg::rsp_t  rsp_o
);

  localparam logic [63:0] I64_MIN_BITS = {1'b1, {63{1'b0}}};

  // configuration
  logic [15:0] lock_count_q;
  logic [31:0] outlier_limit_q, holdover_misses_q, unlock_timeout_q;

  // servo state
  logic [1:0]  lock_q;
  logic [15:0] valid_beacons_q;
  logic [31:0] missed_q, age_q, drift_q;
  logic [63:0] offset_q, prev_m_q, prev_l_q, pulse_q;

  // request and per-item results
  bcss_pkg::req_t req_q;
  logic        reject_q, need_div_q, neg_q;
  logic        reject_d, need_div_d;
  logic [63:0] obs_q, df_mag_q, dl_q, mag_q;
  logic        pos_q;

  // multiply and divide
  logic [127:0] num_q;
  logic [63:0]  rem_q;
  logic [32:0]  quo_q;
  logic [7:0]   cnt_q;
  logic         big_q;
  bcss_pkg::rsp_t rsp_q, rsp_d;

  // combinational checks on the incoming request, captured with it at load
  logic [63:0] m, l, pe_mag, df_abs;
  logic        obs_ok, dm_ok, dl_ok, pe_pos;
  logic signed [64:0] obs_s, off_s, pe_s, dm_s, dl_s, df_s;

  always_comb begin
    m = req_i.master_tick_in;
    l = req_i.local_tick_in;
    // exact differences, usable while the magnitude fits in 63 bits
    obs_s = $signed({1'b0, m}) - $signed({1'b0, l});
    obs_ok = (obs_s[64] == obs_s[63]) && (obs_s[63:0] != I64_MIN_BITS);
    off_s = $signed({offset_q[63], offset_q});
    pe_s = obs_s - off_s;
    pe_pos = !pe_s[64];
    pe_mag = pe_pos ? pe_s[63:0] : 64'(-pe_s);
    dm_s = $signed({1'b0, m}) - $signed({1'b0, prev_m_q});
    dl_s = $signed({1'b0, l}) - $signed({1'b0, prev_l_q});
    dm_ok = !dm_s[64] && !dm_s[63] && dm_s[62:0] != 63'd0;
    dl_ok = !dl_s[64] && !dl_s[63] && dl_s[62:0] != 63'd0;
    df_s = dm_s - dl_s;
    df_abs = df_s[64] ? 64'(-df_s) : df_s[63:0];
  end

  always_comb begin
    reject_d = 1'b0;
    need_div_d = 1'b0;
    if (req_i.mode == bcss_pkg::MODE_OBSERVE) begin
      if (req_i.next_pulse_tick <= m || !obs_ok) begin
        reject_d = 1'b1;
      end else if (lock_q == bcss_pkg::LS_LOCKED) begin
        if (pe_mag > {32'd0, outlier_limit_q}) reject_d = 1'b1;
        else if (prev_m_q != 64'd0 && prev_l_q != 64'd0) begin
          if (!dm_ok || !dl_ok) reject_d = 1'b1;
          else need_div_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_count_q <= 16'd10;
      outlier_limit_q <= 32'd200;
      holdover_misses_q <= 32'd5;
      unlock_timeout_q <= 32'd2000000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcss_pkg::REG_LOCK_COUNT:      lock_count_q <= cfg_data_i[15:0];
        bcss_pkg::REG_OUTLIER_LIMIT:   outlier_limit_q <= cfg_data_i;
        bcss_pkg::REG_HOLDOVER_MISSES: holdover_misses_q <= cfg_data_i;
        bcss_pkg::REG_UNLOCK_TIMEOUT:  unlock_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture and classify
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      obs_q <= '0;
      pos_q <= 1'b0;
      mag_q <= '0;
      dl_q <= '0;
      df_mag_q <= '0;
      neg_q <= 1'b0;
      need_div_q <= 1'b0;
      reject_q <= 1'b0;
    end else if (cmd_i.load) begin
      req_q <= req_i;
      obs_q <= obs_s[63:0];
      pos_q <= pe_pos;
      mag_q <= pe_mag;
      dl_q <= dl_s[63:0];
      df_mag_q <= df_abs;
      neg_q <= df_s[64];
      need_div_q <= need_div_d;
      reject_q <= reject_d;
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_done = cnt_q == 8'(bcss_pkg::DIV_STEPS) || big_q;

  // numerator times 10^6 in two 32x20 halves, then restoring division
  logic [64:0] trial;
  logic [63:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[62:0], num_q[127]};
    trial = {rem_q, num_q[127]} - {1'b0, dl_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      big_q <= 1'b0;
    end else begin
      if (cmd_i.mul_lo) begin
        num_q <= {76'd0, 52'(df_mag_q[31:0] * bcss_pkg::PPM_SCALE)};
      end
      if (cmd_i.mul_hi) begin
        num_q <= num_q + {44'd0, 52'(df_mag_q[63:32] * bcss_pkg::PPM_SCALE), 32'd0};
      end
      if (cmd_i.div_init) begin
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
        big_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        num_q <= {num_q[126:0], 1'b0};
        cnt_q <= cnt_q + 8'd1;
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[31:0], 1'b1};
          if (quo_q[32:31] != 2'b00) big_q <= 1'b1;
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[31:0], 1'b0};
          if (quo_q[32:31] != 2'b00) big_q <= 1'b1;
        end
      end
    end
  end

  // saturated drift
  logic [31:0] drift_new;
  always_comb begin
    if (!neg_q) begin
      drift_new = (big_q || quo_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : quo_q[31:0];
    end else begin
      drift_new = (big_q || quo_q > 33'h080000000) ? 32'h80000000 : 32'(-quo_q[31:0]);
    end
  end

  // commit
  logic [31:0] miss_sum, age_sum;
  logic [15:0] vb_inc;
  logic [64:0] conv_s;
  logic [63:0] offset_nx;
  logic [1:0]  lock_obs;
  always_comb begin
    miss_sum = (missed_q > 32'hFFFFFFFF - req_q.amount) ? 32'hFFFFFFFF
             : missed_q + req_q.amount;
    age_sum = (age_q > 32'hFFFFFFFF - req_q.amount) ? 32'hFFFFFFFF
            : age_q + req_q.amount;
    vb_inc = (valid_beacons_q != 16'hFFFF) ? valid_beacons_q + 16'd1 : valid_beacons_q;
    conv_s = $signed({req_q.master_tick_in[63], req_q.master_tick_in})
           - $signed({offset_q[63], offset_q});
    offset_nx = pos_q ? offset_q + {3'd0, mag_q[63:3]}
                      : offset_q - {3'd0, mag_q[63:3]};
    lock_obs = (vb_inc >= lock_count_q) ? bcss_pkg::LS_LOCKED
                                        : bcss_pkg::LS_ACQUIRING;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= bcss_pkg::LS_UNLOCKED;
      valid_beacons_q <= '0;
      missed_q <= '0;
      age_q <= '0;
      offset_q <= '0;
      drift_q <= '0;
      prev_m_q <= '0;
      prev_l_q <= '0;
      pulse_q <= '0;
    end else if (cmd_i.commit) begin
      case (req_q.mode)
        bcss_pkg::MODE_OBSERVE: begin
          if (!reject_q) begin
            if (lock_q == bcss_pkg::LS_LOCKED) begin
              if (need_div_q) drift_q <= drift_new;
              offset_q <= offset_nx;
            end else begin
              offset_q <= obs_q;
              valid_beacons_q <= vb_inc;
              lock_q <= lock_obs;
            end
            prev_m_q <= req_q.master_tick_in;
            prev_l_q <= req_q.local_tick_in;
            pulse_q <= req_q.next_pulse_tick;
            missed_q <= '0;
            age_q <= '0;
          end
        end
        bcss_pkg::MODE_MISSED: begin
          missed_q <= miss_sum;
          if (lock_q == bcss_pkg::LS_LOCKED && miss_sum >= holdover_misses_q)
            lock_q <= bcss_pkg::LS_HOLDOVER;
        end
        bcss_pkg::MODE_ELAPSED: begin
          age_q <= age_sum;
          if (age_sum > unlock_timeout_q) begin
            lock_q <= bcss_pkg::LS_UNLOCKED;
            valid_beacons_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // response built from the same next-state terms
  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.commit) begin
      rsp_d.converted_tick = '0;
      rsp_d.status = bcss_pkg::ST_OK;
      rsp_d.lock_state = lock_q;
      rsp_d.offset_out = offset_q;
      rsp_d.drift_out = drift_q;
      rsp_d.pulse_tick_out = pulse_q;
      case (req_q.mode)
        bcss_pkg::MODE_OBSERVE: begin
          if (reject_q) rsp_d.status = bcss_pkg::ST_REJECT;
          else begin
            rsp_d.pulse_tick_out = req_q.next_pulse_tick;
            if (lock_q == bcss_pkg::LS_LOCKED) begin
              if (need_div_q) rsp_d.drift_out = drift_new;
              rsp_d.offset_out = offset_nx;
            end else begin
              rsp_d.offset_out = obs_q;
              rsp_d.lock_state = lock_obs;
            end
          end
        end
        bcss_pkg::MODE_MISSED: begin
          if (lock_q == bcss_pkg::LS_LOCKED && miss_sum >= holdover_misses_q)
            rsp_d.lock_state = bcss_pkg::LS_HOLDOVER;
        end
        bcss_pkg::MODE_ELAPSED: begin
          if (age_sum > unlock_timeout_q) rsp_d.lock_state = bcss_pkg::LS_UNLOCKED;
        end
        bcss_pkg::MODE_CONVERT: begin
          if (lock_q == bcss_pkg::LS_UNLOCKED || lock_q == bcss_pkg::LS_ACQUIRING)
            rsp_d.status = bcss_pkg::ST_NOLOCK;
          else if (conv_s[64] || conv_s[63]) rsp_d.status = bcss_pkg::ST_REJECT;
          else rsp_d.converted_tick = conv_s[62:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_q <= '0;
    else rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 8'(bcss_pkg::DIV_STEPS)) else $error("divider overran");
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && reject_q |=> $stable(offset_q) && $stable(pulse_q))
    else $error("rejected request changed state");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < dl_q) else $error("remainder too big");

endmodule

[sv/beacon_clock_sync_servo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_clock_sync_servo
// clock offset servo with holdover, tracking a master clock from beacons
// ----------------------------------------------------------------------------
// One request at a time. Missed-beacon, elapsed-time and conversion requests,
// and observations that are rejected or need no drift update, pass through a
// check state and a commit state from acceptance to response. A locked
// observation with a previous sample first forms the numerator times 10^6 in
// two 32-bit halves, then runs a restoring divider that produces one quotient
// bit per cycle over the 128-bit numerator, stopping early once the quotient
// leaves the 32-bit range. The response sits in an output register, so a new
// request is taken in the cycle its predecessor's response is removed.
// Configuration writes are always ready and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module beacon_clock_sync_servo (
  input  logic            clk_i,
  input  logic            rst_ni,
  // request channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bcss_pkg::req_t  in_data_i,
  // response channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bcss_pkg::rsp_t  out_data_o,
  // configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  bcss_pkg::cmd_t cmd;
  bcss_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  bcss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bcss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_data_o)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the beacon clock sync servo: a queue-fed driver and
// a monitor check every response against a servo model kept in the bench
// ----------------------------------------------------------------------------
module tb;

  localparam logic signed [64:0] TICK_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic in_valid = 1'b0;
  logic in_stall;
  bcss_pkg::req_t in_data = '0;
  logic in_took = 1'b0;
  // response side
  logic out_valid;
  logic out_stall = 1'b0;
  bcss_pkg::rsp_t out_data;
  // configuration side
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bcss_pkg::req_t pending_reqs[$];
  bcss_pkg::rsp_t servo_expect[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;  // no idling on either side in the closing part

  // servo configuration as the bench sees it
  logic [15:0] lock_cnt_cfg;
  logic [31:0] outlier_cfg;
  logic [31:0] holdover_cfg;
  logic [31:0] timeout_cfg;
  // servo state mirror
  logic [1:0]  ls_q;
  logic [15:0] beacons_q;
  logic [31:0] missed_q;
  logic [31:0] age_q;
  logic [63:0] offset_q;
  logic [31:0] drift_q;
  logic [63:0] prev_m_q;
  logic [63:0] prev_l_q;
  logic [63:0] pulse_q;

  // stimulus timeline of a well-behaved master and local clock
  logic [63:0] cur_m;
  logic [63:0] cur_l;

  beacon_clock_sync_servo DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // a tick difference is usable only while its magnitude fits in 63 bits
  function automatic bit tick_fits(logic signed [64:0] d);
    return (d <= TICK_MAX) && (d >= -TICK_MAX);
  endfunction

  function automatic logic signed [64:0] tick_sub(logic [63:0] a, logic [63:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // advance the servo mirror by one request and return the response it owes
  function automatic bcss_pkg::rsp_t servo_predict(bcss_pkg::req_t r);
    bcss_pkg::rsp_t o;
    logic signed [64:0] obs, err, dm, dl, df, cv;
    logic [64:0] mag, adf;
    logic [127:0] num, quo;
    logic [31:0] nd;
    logic [32:0] sum;
    bit ok;
    o = '0;
    o.status = bcss_pkg::ST_OK;
    case (r.mode)
      bcss_pkg::MODE_OBSERVE: begin
        obs = tick_sub(r.master_tick_in, r.local_tick_in);
        ok = (r.next_pulse_tick > r.master_tick_in) && tick_fits(obs);
        if (ok && ls_q == bcss_pkg::LS_LOCKED) begin
          err = obs - $signed({offset_q[63], offset_q});
          mag = (err < 0) ? -err : err;
          nd = drift_q;
          if (mag > {33'd0, outlier_cfg}) ok = 0;
          // drift only once a previous sample exists on both clocks
          if (ok && prev_m_q != 0 && prev_l_q != 0) begin
            dm = tick_sub(r.master_tick_in, prev_m_q);
            dl = tick_sub(r.local_tick_in, prev_l_q);
            if (!tick_fits(dm) || !tick_fits(dl) || dm <= 0 || dl <= 0) begin
              ok = 0;
            end else begin
              df = dm - dl;
              adf = (df < 0) ? -df : df;
              num = 128'(adf);
              num = num * 128'd1000000;
              quo = num / {64'd0, dl[63:0]};
              if (df < 0) nd = (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
              else nd = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
            end
          end
          if (ok) begin
            drift_q = nd;
            offset_q = (err >= 0) ? offset_q + mag[66-3:3] : offset_q - mag[66-3:3];
          end
        end else if (ok) begin
          // any state other than locked takes the raw offset
          offset_q = obs[63:0];
          if (beacons_q != 16'hFFFF) beacons_q = beacons_q + 16'd1;
          ls_q = (beacons_q >= lock_cnt_cfg) ? bcss_pkg::LS_LOCKED : bcss_pkg::LS_ACQUIRING;
        end
        if (ok) begin
          prev_m_q = r.master_tick_in;
          prev_l_q = r.local_tick_in;
          pulse_q = r.next_pulse_tick;
          missed_q = '0;
          age_q = '0;
        end else begin
          o.status = bcss_pkg::ST_REJECT;
        end
      end
      bcss_pkg::MODE_MISSED: begin
        sum = {1'b0, missed_q} + {1'b0, r.amount};
        missed_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (ls_q == bcss_pkg::LS_LOCKED && missed_q >= holdover_cfg)
          ls_q = bcss_pkg::LS_HOLDOVER;
      end
      bcss_pkg::MODE_ELAPSED: begin
        sum = {1'b0, age_q} + {1'b0, r.amount};
        age_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (age_q > timeout_cfg) begin
          ls_q = bcss_pkg::LS_UNLOCKED;
          beacons_q = '0;
        end
      end
      default: begin
        if (ls_q == bcss_pkg::LS_UNLOCKED || ls_q == bcss_pkg::LS_ACQUIRING) begin
          o.status = bcss_pkg::ST_NOLOCK;
        end else begin
          cv = $signed({r.master_tick_in[63], r.master_tick_in})
             - $signed({offset_q[63], offset_q});
          if (cv < 0 || cv > TICK_MAX) o.status = bcss_pkg::ST_REJECT;
          else o.converted_tick = cv[62:0];
        end
      end
    endcase
    o.lock_state = ls_q;
    o.offset_out = offset_q;
    o.drift_out = drift_q;
    o.pulse_tick_out = pulse_q;
    return o;
  endfunction

  // driver: new request or idle burst after the held one has gone
  always @(negedge clk) begin
    int gap;
    logic nv;
    bcss_pkg::req_t nd;
    int ostall_left;
    logic ns;
    nv = in_valid;
    nd = in_data;
    if (!in_valid || in_took) begin
      nv = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 12) - 1;
      end else if (pending_reqs.size() != 0) begin
        nd = pending_reqs.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_data <= nd;
    // receiver stall bursts
    ns = 1'b0;
    if (ostall_left > 0) begin
      ostall_left--;
      ns = 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      ostall_left = $urandom_range(1, 12) - 1;
      ns = 1'b1;
    end
    out_stall <= ns;
  end

  // monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    bcss_pkg::rsp_t exp_r;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) servo_expect.push_back(servo_predict(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (servo_expect.size() == 0) begin
        $error("response with none expected: %h", out_data);
        errors++;
      end else begin
        exp_r = servo_expect.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.lock_state !== exp_r.lock_state) begin
          $error("lock_state exp %0d got %0d", exp_r.lock_state, out_data.lock_state);
          errors++;
        end
        if (out_data.offset_out !== exp_r.offset_out) begin
          $error("offset_out exp %0d got %0d", exp_r.offset_out, out_data.offset_out);
          errors++;
        end
        if (out_data.drift_out !== exp_r.drift_out) begin
          $error("drift_out exp %0d got %0d", exp_r.drift_out, out_data.drift_out);
          errors++;
        end
        if (out_data.converted_tick !== exp_r.converted_tick) begin
          $error("converted_tick exp %0d got %0d", exp_r.converted_tick,
                 out_data.converted_tick);
          errors++;
        end
        if (out_data.pulse_tick_out !== exp_r.pulse_tick_out) begin
          $error("pulse_tick_out exp %0d got %0d", exp_r.pulse_tick_out,
                 out_data.pulse_tick_out);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // register write, only ever issued while the servo is idle
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcss_pkg::REG_LOCK_COUNT:      lock_cnt_cfg = val[15:0];
      bcss_pkg::REG_OUTLIER_LIMIT:   outlier_cfg = val;
      bcss_pkg::REG_HOLDOVER_MISSES: holdover_cfg = val;
      default:                       timeout_cfg = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every request has gone and every response has come back
  task automatic drain;
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || servo_expect.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic bcss_pkg::req_t mk(logic [1:0] md, logic [63:0] m, logic [63:0] l,
                                        logic [63:0] np, logic [31:0] amt);
    bcss_pkg::req_t r;
    r.mode = md;
    r.master_tick_in = m;
    r.local_tick_in = l;
    r.next_pulse_tick = np;
    r.amount = amt;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // one random request, mostly a coherent beacon timeline
  task automatic push_random;
    int unsigned sel;
    logic [63:0] step;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 199) == 0) begin
      // fresh timeline, sometimes from a zero sample
      cur_m = ($urandom_range(0, 3) == 0) ? 64'd0 : {32'd0, $urandom};
      cur_l = cur_m - {{32{1'b0}}, $urandom_range(0, 100000)};
    end
    if (sel < 55) begin
      step = 64'($urandom_range(900, 1100));
      cur_m = cur_m + step;
      cur_l = cur_l + step + $urandom_range(0, 6) - 3;
      // occasional outlier-sized jump of the local stamp
      pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, cur_m,
        ($urandom_range(0, 19) == 0) ? cur_l + $urandom_range(0, 1000) : cur_l,
        cur_m + $urandom_range(1, 2000), $urandom));
    end else if (sel < 62) begin
      case ($urandom_range(0, 2))
        0: pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, cur_m, cur_l,
                                     cur_m - $urandom_range(0, 3), $urandom));
        1: pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, cur_m - 5, cur_l + 5,
                                     cur_m + 9, '0));
        default: pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, cur_m + 1000,
                                           cur_l - 7, cur_m + 2000, '0));
      endcase
    end else if (sel < 70) begin
      pending_reqs.push_back(mk(bcss_pkg::MODE_MISSED, rnd64(), rnd64(), rnd64(),
        ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3)));
    end else if (sel < 78) begin
      pending_reqs.push_back(mk(bcss_pkg::MODE_ELAPSED, rnd64(), rnd64(), rnd64(),
        ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3000)));
    end else if (sel < 92) begin
      pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT,
        ($urandom_range(0, 3) == 0) ? rnd64() : cur_m + $urandom_range(0, 5000),
        rnd64(), rnd64(), $urandom));
    end else begin
      pending_reqs.push_back(mk(2'($urandom_range(0, 3)), rnd64(), rnd64(), rnd64(),
                                $urandom));
    end
  endtask

  initial begin
    logic [15:0] lc_set[8] = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd10, 16'd1, 16'd4};
    logic [31:0] ol_set[8] = '{32'd200, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd200,
                               32'd1000, 32'd200, 32'd100};
    logic [31:0] hm_set[8] = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd5, 32'd1, 32'd5, 32'd3};
    logic [31:0] ut_set[8] = '{32'd2000000, 32'd0, 32'hFFFF_FFFF, 32'd5000,
                               32'd20000, 32'd2000000, 32'd3000, 32'd100000};
    lock_cnt_cfg = 16'd10;
    outlier_cfg = 32'd200;
    holdover_cfg = 32'd5;
    timeout_cfg = 32'd2000000;
    ls_q = bcss_pkg::LS_UNLOCKED;
    beacons_q = '0;
    missed_q = '0;
    age_q = '0;
    offset_q = '0;
    drift_q = '0;
    prev_m_q = '0;
    prev_l_q = '0;
    pulse_q = '0;
    cur_m = 64'd1000000;
    cur_l = 64'd990000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, conversion before lock, range errors
    pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT, 64'd5, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, '0, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd100, 64'd50, 64'd100, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'h8000_0000_0000_0000, '0, '1, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, '0, 64'h8000_0000_0000_0000, 64'd1, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, '1, '1, '1, '1));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'h7FFF_FFFF_FFFF_FFFF, '0, '1, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_MISSED, '1, '1, '1, '1));
    pending_reqs.push_back(mk(bcss_pkg::MODE_MISSED, '0, '0, '0, 32'd7));
    pending_reqs.push_back(mk(bcss_pkg::MODE_ELAPSED, '0, '0, '0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(bcss_pkg::MODE_ELAPSED, '0, '0, '0, 32'd1));
    drain();
    // lock after one beacon and exercise the locked paths
    cfg_write(bcss_pkg::REG_LOCK_COUNT, 32'd1);
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd1000000, 64'd999000,
                              64'd1001000, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT, 64'h8000_0000_0000_0000, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT, 64'd500, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd1001000, 64'd999990,
                              64'd1002000, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd1002000, 64'd1000995,
                              64'd1003000, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd1002500, 64'd1000994,
                              64'd1003000, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd9_000_000_000, 64'd8_998_998_900,
                              64'd9_000_001_000, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_MISSED, '0, '0, '0, 32'd5));
    pending_reqs.push_back(mk(bcss_pkg::MODE_CONVERT, 64'd2000000, '0, '0, '0));
    pending_reqs.push_back(mk(bcss_pkg::MODE_OBSERVE, 64'd9_000_001_000, 64'd8_999_000_000,
                              64'd9_000_002_000, '0));
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(bcss_pkg::REG_LOCK_COUNT, {16'd0, lc_set[ph]});
      cfg_write(bcss_pkg::REG_OUTLIER_LIMIT, ol_set[ph]);
      cfg_write(bcss_pkg::REG_HOLDOVER_MISSES, hm_set[ph]);
      cfg_write(bcss_pkg::REG_UNLOCK_TIMEOUT, ut_set[ph]);
      // hold the sender until the whole phase has come back
      for (int k = 0; k < 170; k++) push_random();
      drain();
    end

    // closing part without idling
    cfg_write(bcss_pkg::REG_LOCK_COUNT, 32'd2);
    cfg_write(bcss_pkg::REG_OUTLIER_LIMIT, 32'd300);
    quiet = 1'b1;
    for (int k = 0; k < 160; k++) push_random();
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/bcss_pkg.sv
sv/bcss_ctrl.sv
sv/bcss_datapath.sv
sv/beacon_clock_sync_servo.sv
sim/tb.sv
